FILE: rtl/core/aabb_pkg.sv
// Shared widths, payload types and register codes for the box transform.
package aabb_pkg;

  // Fixed-point formats
  localparam int COORD_WIDTH = 32;                // signed Q16.16 coordinates
  localparam int COEFF_WIDTH = 16;                // signed Q2.14 coefficients
  localparam int COEFF_FRAC  = COEFF_WIDTH - 2;
  localparam int ROW_WIDTH   = 3 * COEFF_WIDTH;   // one packed coefficient row
  localparam int PROD_WIDTH  = COORD_WIDTH + COEFF_WIDTH;
  localparam int TERM_WIDTH  = PROD_WIDTH - COEFF_FRAC;   // rounded product
  localparam int SUM_WIDTH   = TERM_WIDTH + 2;            // offset plus three terms

  // APB register map: registers are 64 bits wide, one per 8 bytes
  localparam int NUM_REGS    = 6;
  localparam int APB_DATA_W  = 64;
  localparam int APB_ADDR_W  = $clog2(NUM_REGS * 8);
  localparam int REG_IDX_W   = APB_ADDR_W - 3;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_COEFF_X  = 3'd0,
    REG_COEFF_Y  = 3'd1,
    REG_COEFF_Z  = 3'd2,
    REG_OFFSET_X = 3'd3,
    REG_OFFSET_Y = 3'd4,
    REG_OFFSET_Z = 3'd5
  } reg_idx_t;

  // Coefficient value 1.0 in Q2.14
  localparam logic [ROW_WIDTH-1:0] COEFF_ONE = ROW_WIDTH'(1) << COEFF_FRAC;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic signed [COEFF_WIDTH-1:0] coeff_t;
  typedef logic signed [PROD_WIDTH-1:0]  prod_t;
  typedef logic signed [TERM_WIDTH-1:0]  term_t;
  typedef logic signed [SUM_WIDTH-1:0]   sum_t;

  // Input beat: box corners
  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] lo_x;
    logic signed [COORD_WIDTH-1:0] lo_y;
    logic signed [COORD_WIDTH-1:0] lo_z;
    logic signed [COORD_WIDTH-1:0] hi_x;
    logic signed [COORD_WIDTH-1:0] hi_y;
    logic signed [COORD_WIDTH-1:0] hi_z;
  } box_in_t;

  // Result beat: transformed box corners
  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] new_lo_x;
    logic signed [COORD_WIDTH-1:0] new_lo_y;
    logic signed [COORD_WIDTH-1:0] new_lo_z;
    logic signed [COORD_WIDTH-1:0] new_hi_x;
    logic signed [COORD_WIDTH-1:0] new_hi_y;
    logic signed [COORD_WIDTH-1:0] new_hi_z;
  } box_out_t;

  // Transform settings handed from the register file to the datapath
  typedef struct packed {
    logic [2:0][ROW_WIDTH-1:0]   coeffs;   // row i drives output axis i
    logic [2:0][COORD_WIDTH-1:0] offsets;
  } xform_cfg_t;

endpackage

FILE: rtl/core/aabb_rigid_transform.sv
// Top level: axis-aligned box through a 3x3 map and translation, four-stage pipeline.
//
// Takes one box per clock and returns its enclosing box after the programmed
// linear map and translation. busy never rises, so start may be held high every
// cycle. Each result appears on out_data for one cycle with out_valid high, once
// its box has passed the multiply, round and sort, sum and saturate registers in
// turn; the receiver must take it in that cycle, as there is no hold-off.
// Results leave in the order boxes arrive. Write the APB registers only while no
// box is in flight, since the multiply and sum stages read them directly.
module aabb_rigid_transform
  import aabb_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // input channel
  input  logic                  start,
  output logic                  busy,
  input  box_in_t               in_data,
  // result channel
  output logic                  out_valid,
  output box_out_t              out_data,
  // configuration
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  xform_cfg_t cfg;
  logic       mul_valid;
  prod_t      prod_lo [3][3];
  prod_t      prod_hi [3][3];
  logic       ord_valid;
  term_t      term_min [3][3];
  term_t      term_max [3][3];

  // Fully pipelined: never stalls the sender
  assign busy = 1'b0;

  aabb_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  aabb_mul u_mul (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (start & ~busy),
    .box      (in_data),
    .cfg      (cfg),
    .valid    (mul_valid),
    .prod_lo  (prod_lo),
    .prod_hi  (prod_hi)
  );

  aabb_order u_order (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (mul_valid),
    .prod_lo  (prod_lo),
    .prod_hi  (prod_hi),
    .valid    (ord_valid),
    .term_min (term_min),
    .term_max (term_max)
  );

  aabb_accum u_accum (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (ord_valid),
    .term_min (term_min),
    .term_max (term_max),
    .cfg      (cfg),
    .valid    (out_valid),
    .box      (out_data)
  );

endmodule

FILE: rtl/core/aabb_cfg_regs.sv
// APB register file holding the coefficient rows and the translation.
module aabb_cfg_regs
  import aabb_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output xform_cfg_t            cfg
);

  xform_cfg_t           cfg_r;
  xform_cfg_t           cfg_nxt;
  logic [REG_IDX_W-1:0] idx;
  logic                 wr_en;

  assign pready = 1'b1;
  assign idx    = paddr[APB_ADDR_W-1:3];
  assign wr_en  = psel & penable & pwrite;
  assign cfg    = cfg_r;

  // Write decode
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        REG_COEFF_X:  cfg_nxt.coeffs[0]  = pwdata[ROW_WIDTH-1:0];
        REG_COEFF_Y:  cfg_nxt.coeffs[1]  = pwdata[ROW_WIDTH-1:0];
        REG_COEFF_Z:  cfg_nxt.coeffs[2]  = pwdata[ROW_WIDTH-1:0];
        REG_OFFSET_X: cfg_nxt.offsets[0] = pwdata[COORD_WIDTH-1:0];
        REG_OFFSET_Y: cfg_nxt.offsets[1] = pwdata[COORD_WIDTH-1:0];
        REG_OFFSET_Z: cfg_nxt.offsets[2] = pwdata[COORD_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // Identity map, no translation after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        cfg_r.coeffs[i]  <= COEFF_ONE << (COEFF_WIDTH * i);
        cfg_r.offsets[i] <= '0;
      end
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Read mux, zero-extended
  always_comb begin
    unique case (idx)
      REG_COEFF_X:  prdata = APB_DATA_W'(cfg_r.coeffs[0]);
      REG_COEFF_Y:  prdata = APB_DATA_W'(cfg_r.coeffs[1]);
      REG_COEFF_Z:  prdata = APB_DATA_W'(cfg_r.coeffs[2]);
      REG_OFFSET_X: prdata = APB_DATA_W'(cfg_r.offsets[0]);
      REG_OFFSET_Y: prdata = APB_DATA_W'(cfg_r.offsets[1]);
      REG_OFFSET_Z: prdata = APB_DATA_W'(cfg_r.offsets[2]);
      default:      prdata = '0;
    endcase
  end

endmodule

FILE: rtl/core/aabb_mul.sv
// Stage 1: the eighteen coefficient-by-corner products, registered.
module aabb_mul
  import aabb_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  box_in_t    box,
  input  xform_cfg_t cfg,
  output logic       valid,
  output prod_t      prod_lo [3][3],
  output prod_t      prod_hi [3][3]
);

  logic   valid_r;
  prod_t  prod_lo_r  [3][3];
  prod_t  prod_hi_r  [3][3];
  prod_t  prod_lo_nxt[3][3];
  prod_t  prod_hi_nxt[3][3];
  coord_t lo [3];
  coord_t hi [3];

  assign lo[0] = box.lo_x;
  assign lo[1] = box.lo_y;
  assign lo[2] = box.lo_z;
  assign hi[0] = box.hi_x;
  assign hi[1] = box.hi_y;
  assign hi[2] = box.hi_z;

  // Row i, column j: M[i][j] times each corner coordinate
  always_comb begin
    coeff_t c;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        c = coeff_t'(cfg.coeffs[i][COEFF_WIDTH*j +: COEFF_WIDTH]);
        prod_lo_nxt[i][j] = prod_t'(lo[j]) * prod_t'(c);
        prod_hi_nxt[i][j] = prod_t'(hi[j]) * prod_t'(c);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    prod_lo_r <= prod_lo_nxt;
    prod_hi_r <= prod_hi_nxt;
  end

  assign valid   = valid_r;
  assign prod_lo = prod_lo_r;
  assign prod_hi = prod_hi_r;

endmodule

FILE: rtl/core/aabb_order.sv
// Stage 2: round each product to nearest and sort each pair into min and max.
module aabb_order
  import aabb_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  input  prod_t prod_lo [3][3],
  input  prod_t prod_hi [3][3],
  output logic  valid,
  output term_t term_min [3][3],
  output term_t term_max [3][3]
);

  localparam prod_t HALF_LSB = prod_t'(1) <<< (COEFF_FRAC - 1);

  logic  valid_r;
  term_t term_min_r  [3][3];
  term_t term_max_r  [3][3];
  term_t term_min_nxt[3][3];
  term_t term_max_nxt[3][3];

  // Ties round up: add half an LSB, then arithmetic shift
  always_comb begin
    prod_t a;
    prod_t b;
    term_t e;
    term_t f;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        a = prod_lo[i][j] + HALF_LSB;
        b = prod_hi[i][j] + HALF_LSB;
        e = term_t'(a >>> COEFF_FRAC);
        f = term_t'(b >>> COEFF_FRAC);
        if (e < f) begin
          term_min_nxt[i][j] = e;
          term_max_nxt[i][j] = f;
        end else begin
          term_min_nxt[i][j] = f;
          term_max_nxt[i][j] = e;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    term_min_r <= term_min_nxt;
    term_max_r <= term_max_nxt;
  end

  assign valid    = valid_r;
  assign term_min = term_min_r;
  assign term_max = term_max_r;

endmodule

FILE: rtl/core/aabb_accum.sv
// Stages 3 and 4: exact sum of offset and terms, then saturation to the output beat.
module aabb_accum
  import aabb_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  term_t      term_min [3][3],
  input  term_t      term_max [3][3],
  input  xform_cfg_t cfg,
  output logic       valid,
  output box_out_t   box
);

  localparam sum_t SAT_MAX = sum_t'({1'b0, {(COORD_WIDTH-1){1'b1}}});
  localparam sum_t SAT_MIN = -SAT_MAX - sum_t'(1);

  logic     sum_valid_r;
  sum_t     sum_min_r  [3];
  sum_t     sum_max_r  [3];
  sum_t     sum_min_nxt[3];
  sum_t     sum_max_nxt[3];
  logic     out_valid_r;
  box_out_t box_r;
  box_out_t box_nxt;
  coord_t   sat_min [3];
  coord_t   sat_max [3];

  // Offset plus the three chosen terms per axis; no overflow at SUM_WIDTH
  always_comb begin
    coord_t off;
    for (int i = 0; i < 3; i++) begin
      off = coord_t'(cfg.offsets[i]);
      sum_min_nxt[i] = sum_t'(off) + sum_t'(term_min[i][0])
                     + sum_t'(term_min[i][1]) + sum_t'(term_min[i][2]);
      sum_max_nxt[i] = sum_t'(off) + sum_t'(term_max[i][0])
                     + sum_t'(term_max[i][1]) + sum_t'(term_max[i][2]);
    end
  end

  always_ff @(posedge clk) begin
    sum_min_r <= sum_min_nxt;
    sum_max_r <= sum_max_nxt;
  end

  // Clamp to the coordinate range
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (sum_min_r[i] > SAT_MAX) begin
        sat_min[i] = coord_t'(SAT_MAX);
      end else if (sum_min_r[i] < SAT_MIN) begin
        sat_min[i] = coord_t'(SAT_MIN);
      end else begin
        sat_min[i] = coord_t'(sum_min_r[i]);
      end
      if (sum_max_r[i] > SAT_MAX) begin
        sat_max[i] = coord_t'(SAT_MAX);
      end else if (sum_max_r[i] < SAT_MIN) begin
        sat_max[i] = coord_t'(SAT_MIN);
      end else begin
        sat_max[i] = coord_t'(sum_max_r[i]);
      end
    end
  end

  always_comb begin
    box_nxt.new_lo_x = sat_min[0];
    box_nxt.new_lo_y = sat_min[1];
    box_nxt.new_lo_z = sat_min[2];
    box_nxt.new_hi_x = sat_max[0];
    box_nxt.new_hi_y = sat_max[1];
    box_nxt.new_hi_z = sat_max[2];
  end

  always_ff @(posedge clk) begin
    box_r <= box_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      sum_valid_r <= in_valid;
      out_valid_r <= sum_valid_r;
    end
  end

  assign valid = out_valid_r;
  assign box   = box_r;

endmodule
